// File: hdl/bpnt_pkg.sv
`timescale 1ns / 1ps
package bpnt_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  // Status codes of a result.
  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_NOROUTE = 2'd2;
  localparam logic [1:0] ST_UNKNOWN = 2'd3;

  // Request modes.
  localparam logic [1:0] MODE_REPORT = 2'd0;
  localparam logic [1:0] MODE_LINK   = 2'd1;
  localparam logic [1:0] MODE_ROUTE  = 2'd2;

  // Configuration register indexes.
  localparam logic [7:0] CFG_LOSS_FACTOR = 8'd0;
  localparam logic [7:0] CFG_LIFETIME    = 8'd1;

  // ETX numerator is loss * (33-bit total) * 100, 48 bits wide.
  localparam int NUM_W     = 48;
  localparam int DIV_CNT_W = 6;
  localparam logic [DIV_CNT_W-1:0] DIV_STEPS = DIV_CNT_W'(NUM_W);

  // x / 100 for 16-bit x as (x * 83887) >> 23.
  localparam logic [16:0] RECIP_100 = 17'd83887;
  localparam int RECIP_SHIFT = 23;

  localparam logic [14:0] BACKLOG_LIMIT = 15'd25;
  localparam logic [6:0] SCALE_100 = 7'd100;

  typedef struct packed {
    logic       load_in;
    logic       idx_clr;
    logic       idx_inc;
    logic       upd_known;
    logic       append;
    logic       link_upd;
    logic       mul1;
    logic       mul2;
    logic       div_step;
    logic       eval;
    logic       set_res;
    logic [1:0] res_code;
    logic       route_res;
    logic       out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       idx_end;
    logic       match;
    logic       full;
    logic       life_zero;
    logic       div_done;
    logic       out_free;
  } dp_sts_t;

endpackage

// File: hdl/bpnt_ctrl.sv
`timescale 1ns / 1ps
module bpnt_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [1:0]        s_tuser,
  input  bpnt_pkg::dp_sts_t sts,
  output bpnt_pkg::dp_cmd_t cmd
);
  import bpnt_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_FIND   = 4'd1;
  localparam logic [3:0] S_SCAN   = 4'd2;
  localparam logic [3:0] S_MUL2   = 4'd3;
  localparam logic [3:0] S_DIV    = 4'd4;
  localparam logic [3:0] S_EVAL   = 4'd5;
  localparam logic [3:0] S_RESULT = 4'd6;

  logic [3:0] state;
  logic [3:0] state_next;

  assign s_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load_in = 1'b1;
          cmd.idx_clr = 1'b1;
          if (s_tuser == MODE_REPORT || s_tuser == MODE_LINK) begin
            state_next = S_FIND;
          end else if (s_tuser == MODE_ROUTE) begin
            state_next = S_SCAN;
          end else begin
            cmd.set_res = 1'b1;
            cmd.res_code = ST_DONE;
            state_next = S_RESULT;
          end
        end
      end
      S_FIND: begin
        if (sts.idx_end) begin
          cmd.set_res = 1'b1;
          state_next = S_RESULT;
          if (sts.mode == MODE_LINK) begin
            cmd.res_code = ST_UNKNOWN;
          end else if (sts.full) begin
            cmd.res_code = ST_FULL;
          end else begin
            cmd.res_code = ST_DONE;
            cmd.append = 1'b1;
          end
        end else if (sts.match) begin
          cmd.set_res = 1'b1;
          cmd.res_code = ST_DONE;
          cmd.upd_known = (sts.mode == MODE_REPORT);
          cmd.link_upd = (sts.mode == MODE_LINK);
          state_next = S_RESULT;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_SCAN: begin
        if (sts.idx_end) begin
          cmd.route_res = 1'b1;
          state_next = S_RESULT;
        end else if (sts.life_zero) begin
          cmd.idx_inc = 1'b1;
        end else begin
          cmd.mul1 = 1'b1;
          state_next = S_MUL2;
        end
      end
      S_MUL2: begin
        cmd.mul2 = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        if (sts.div_done) begin
          state_next = S_EVAL;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_EVAL: begin
        cmd.eval = 1'b1;
        cmd.idx_inc = 1'b1;
        state_next = S_SCAN;
      end
      S_RESULT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// File: hdl/bpnt_dpath.sv
`timescale 1ns / 1ps
module bpnt_dpath (
  input  logic              clk,
  input  logic              rst,
  input  bpnt_pkg::dp_cmd_t cmd,
  output bpnt_pkg::dp_sts_t sts,
  input  logic [1:0]        s_tuser,
  input  logic [31:0]       s_tdata,
  input  logic              cfg_valid,
  input  logic [7:0]        cfg_index,
  input  logic [7:0]        cfg_data,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [1:0]        m_tuser,
  output logic [31:0]       m_tdata
);
  import bpnt_pkg::*;

  logic [7:0] loss_factor;
  logic [7:0] lifetime_init;

  logic [1:0]  in_mode;
  logic [15:0] in_addr;
  logic [14:0] in_bl;
  logic        in_ok;

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] idx;
  logic [IDX_W-1:0] ix;

  logic [15:0] e_addr [TABLE_ENTRIES];
  logic [14:0] e_bl   [TABLE_ENTRIES];
  logic [7:0]  e_life [TABLE_ENTRIES];
  logic        e_ok   [TABLE_ENTRIES];
  logic [31:0] c_ss   [TABLE_ENTRIES];
  logic [31:0] c_sf   [TABLE_ENTRIES];
  logic [31:0] c_fs   [TABLE_ENTRIES];
  logic [31:0] c_ff   [TABLE_ENTRIES];

  logic [40:0]          prod1;
  logic [NUM_W-1:0]     quo;
  logic [31:0]          rem;
  logic [DIV_CNT_W-1:0] div_cnt;

  logic signed [25:0] best;
  logic               found;
  logic [15:0]        pick_addr;
  logic [14:0]        pick_bl;

  logic [1:0]  res_status;
  logic [15:0] res_addr;
  logic [14:0] res_bl;

  logic [31:0]        s_sel;
  logic [32:0]        t_sel;
  logic [32:0]        rem_sh;
  logic [32:0]        rem_sub;
  logic [15:0]        etx;
  logic [32:0]        etx_prod;
  logic [9:0]         etx_d100;
  logic signed [16:0] diff;
  logic signed [25:0] weight;
  logic               skip;

  assign ix = idx[IDX_W-1:0];

  assign s_sel = e_ok[ix] ? c_ss[ix] : c_fs[ix];
  assign t_sel = e_ok[ix] ? ({1'b0, c_ss[ix]} + {1'b0, c_sf[ix]})
                          : ({1'b0, c_fs[ix]} + {1'b0, c_ff[ix]});

  assign rem_sh  = {rem, quo[NUM_W-1]};
  assign rem_sub = rem_sh - {1'b0, s_sel};

  assign etx      = (s_sel == 32'd0) ? 16'hFFFF : quo[15:0];
  assign etx_prod = {1'b0, etx} * {16'd0, RECIP_100};
  assign etx_d100 = etx_prod[RECIP_SHIFT +: 10];
  assign diff     = $signed({2'b00, in_bl}) - $signed({2'b00, e_bl[ix]});
  assign weight   = $signed(26'(diff) * 26'(SCALE_100)) - $signed({10'd0, etx});
  assign skip     = diff[16] || (diff < $signed({7'd0, etx_d100}))
                    || (e_bl[ix] >= BACKLOG_LIMIT);

  always_comb begin
    sts.mode      = in_mode;
    sts.idx_end   = (idx == count);
    sts.match     = (e_addr[ix] == in_addr);
    sts.full      = (count == CNT_W'(TABLE_ENTRIES));
    sts.life_zero = (e_life[ix] == 8'd0);
    sts.div_done  = (div_cnt == DIV_STEPS);
    sts.out_free  = !m_tvalid || m_tready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      loss_factor <= 8'd1;
      lifetime_init <= 8'd5;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_LOSS_FACTOR) begin
        loss_factor <= cfg_data;
      end else if (cfg_index == CFG_LIFETIME) begin
        lifetime_init <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      idx <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.append) begin
        count <= count + 1'b1;
      end
      if (cmd.idx_clr) begin
        idx <= '0;
      end else if (cmd.idx_inc) begin
        idx <= idx + 1'b1;
      end
      if (cmd.out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_mode <= s_tuser;
      in_addr <= s_tdata[15:0];
      in_bl   <= s_tdata[30:16];
      in_ok   <= s_tdata[31];
      best    <= -26'sd1;
      found   <= 1'b0;
    end
    if (cmd.upd_known) begin
      e_bl[ix]   <= in_bl;
      e_life[ix] <= lifetime_init;
    end
    if (cmd.append) begin
      e_addr[ix] <= in_addr;
      e_bl[ix]   <= in_bl;
      e_life[ix] <= lifetime_init;
      e_ok[ix]   <= 1'b1;
      c_ss[ix]   <= 32'd1;
      c_sf[ix]   <= 32'd0;
      c_fs[ix]   <= 32'd1;
      c_ff[ix]   <= 32'd0;
    end
    if (cmd.link_upd) begin
      e_ok[ix] <= in_ok;
      if (in_ok && e_ok[ix] && c_ss[ix] != '1) begin
        c_ss[ix] <= c_ss[ix] + 32'd1;
      end
      if (in_ok && !e_ok[ix] && c_fs[ix] != '1) begin
        c_fs[ix] <= c_fs[ix] + 32'd1;
      end
      if (!in_ok && e_ok[ix] && c_sf[ix] != '1) begin
        c_sf[ix] <= c_sf[ix] + 32'd1;
      end
      if (!in_ok && !e_ok[ix] && c_ff[ix] != '1) begin
        c_ff[ix] <= c_ff[ix] + 32'd1;
      end
    end
    if (cmd.mul1) begin
      prod1 <= {33'd0, loss_factor} * {8'd0, t_sel};
    end
    if (cmd.mul2) begin
      quo     <= {7'd0, prod1} * {41'd0, SCALE_100};
      rem     <= '0;
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      div_cnt <= div_cnt + 1'b1;
      if (!rem_sub[32]) begin
        rem <= rem_sub[31:0];
        quo <= {quo[NUM_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh[31:0];
        quo <= {quo[NUM_W-2:0], 1'b0};
      end
    end
    if (cmd.eval && !skip) begin
      e_life[ix] <= e_life[ix] - 8'd1;
      if (weight > best) begin
        best      <= weight;
        found     <= 1'b1;
        pick_addr <= e_addr[ix];
        pick_bl   <= e_bl[ix];
      end
    end
    if (cmd.set_res) begin
      res_status <= cmd.res_code;
      res_addr   <= '0;
      res_bl     <= '0;
    end else if (cmd.route_res) begin
      if (found && best > 26'sd0) begin
        res_status <= ST_DONE;
        res_addr   <= pick_addr;
        res_bl     <= pick_bl;
      end else begin
        res_status <= ST_NOROUTE;
        res_addr   <= '0;
        res_bl     <= '0;
      end
    end
    if (cmd.out_load) begin
      m_tuser <= res_status;
      m_tdata <= {1'b0, res_bl, res_addr};
    end
  end

endmodule

// File: hdl/backpressure_neighbor_table.sv
`timescale 1ns / 1ps
// Neighbor table for backpressure routing. Each request carries a mode in
// s_tuser: a neighbor report (mode 0) refreshes or appends a neighbor, a link
// outcome (mode 1) updates that neighbor's transition counters, and a route
// query (mode 2) picks the neighbor with the best positive weight. Every
// request gives exactly one result, with its status in m_tuser. Requests are
// handled one at a time: the input stays busy while a report or link outcome
// is accepted, while its address search visits the stored entries one by one
// (all of them when the address is new), and while its result is loaded. A
// route query visits every stored entry; each live entry passes through the
// multipliers and the bit-serial 48-bit ETX divider, and expired entries are
// passed over. A finished result sits in the output register so a new request
// can be taken while it waits; only when a second result is ready before the
// first has left does the block stall. Configuration writes are always
// accepted and should be made while no request is in flight.
module backpressure_neighbor_table (
  input  logic        clk,
  input  logic        rst,
  // Request: tdata = neighbor_address[15:0], backlog_value[30:16],
  // link_success[31]; tuser = mode[1:0].
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,
  input  logic [1:0]  s_tuser,
  // Result: tdata = chosen_address[15:0], chosen_backlog[30:16], zero[31];
  // tuser = status[1:0].
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,
  output logic [1:0]  m_tuser,
  // Configuration writes: index 0 loss factor, index 1 max lifetime.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  import bpnt_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready = 1'b1;

  bpnt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .sts      (sts),
    .cmd      (cmd)
  );

  bpnt_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .s_tuser   (s_tuser),
    .s_tdata   (s_tdata),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tuser   (m_tuser),
    .m_tdata   (m_tdata)
  );

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for the backpressure neighbor table. A behavioral copy of
// the table lives here and predicts the single result of every request; a
// monitor compares each accepted result against the oldest prediction.
module testbench;
  import bpnt_pkg::*;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] addr;
    logic [14:0] backlog;
  } route_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_index = '0;
  logic [7:0]  cfg_data = '0;

  backpressure_neighbor_table u_top (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Shadow copy of the neighbor table.
  logic [7:0]  loss_factor;
  logic [7:0]  life_max;
  int          nbr_count;
  logic [15:0] nbr_addr [TABLE_ENTRIES];
  logic [14:0] nbr_backlog [TABLE_ENTRIES];
  logic [7:0]  nbr_life [TABLE_ENTRIES];
  logic        nbr_last_ok [TABLE_ENTRIES];
  logic [31:0] n_ss [TABLE_ENTRIES];
  logic [31:0] n_sf [TABLE_ENTRIES];
  logic [31:0] n_fs [TABLE_ENTRIES];
  logic [31:0] n_ff [TABLE_ENTRIES];

  route_result_t pending_results[$];
  int  error_count = 0;
  int  result_count = 0;
  int  route_hits = 0;
  int  cycle_count = 0;
  bit  idle_enable = 1'b1;
  bit  hold_sink = 1'b0;

  function automatic logic [31:0] sat_inc(logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  function automatic int find_nbr(logic [15:0] a);
    for (int k = 0; k < nbr_count; k++)
      if (nbr_addr[k] == a) return k;
    return -1;
  endfunction

  function automatic logic [15:0] expected_etx(int k);
    logic [63:0] s, t, q;
    if (nbr_last_ok[k]) begin
      s = n_ss[k];
      t = s + n_sf[k];
    end else begin
      s = n_fs[k];
      t = s + n_ff[k];
    end
    if (s == 0) return 16'hFFFF;
    q = (64'(loss_factor) * t * 64'd100) / s;
    return q[15:0];
  endfunction

  // Applies one request to the shadow table and returns its expected result.
  function automatic route_result_t table_update(logic [1:0] mode, logic [15:0] a,
                                                 logic [14:0] bl, logic ok);
    route_result_t r;
    int k, pick, best, diff, w;
    logic [15:0] etx;
    bit found;
    r = '0;
    k = find_nbr(a);
    case (mode)
      MODE_REPORT: begin
        if (k >= 0) begin
          nbr_backlog[k] = bl;
          nbr_life[k] = life_max;
        end else if (nbr_count >= TABLE_ENTRIES) begin
          r.status = ST_FULL;
        end else begin
          nbr_addr[nbr_count] = a;
          nbr_backlog[nbr_count] = bl;
          nbr_life[nbr_count] = life_max;
          nbr_last_ok[nbr_count] = 1'b1;
          n_ss[nbr_count] = 1;
          n_sf[nbr_count] = 0;
          n_fs[nbr_count] = 1;
          n_ff[nbr_count] = 0;
          nbr_count++;
        end
      end
      MODE_LINK: begin
        if (k < 0) begin
          r.status = ST_UNKNOWN;
        end else begin
          if (ok && nbr_last_ok[k]) n_ss[k] = sat_inc(n_ss[k]);
          else if (ok) n_fs[k] = sat_inc(n_fs[k]);
          else if (nbr_last_ok[k]) n_sf[k] = sat_inc(n_sf[k]);
          else n_ff[k] = sat_inc(n_ff[k]);
          nbr_last_ok[k] = ok;
        end
      end
      MODE_ROUTE: begin
        best = -1;
        found = 0;
        pick = 0;
        for (int j = 0; j < nbr_count; j++) begin
          if (nbr_life[j] == 0) continue;
          etx = expected_etx(j);
          diff = int'(bl) - int'(nbr_backlog[j]);
          if (diff < 0 || diff < int'(etx / 100) || nbr_backlog[j] >= 25) continue;
          nbr_life[j] = nbr_life[j] - 8'd1;
          w = diff * 100 - int'(etx);
          if (w > best) begin
            best = w;
            pick = j;
            found = 1;
          end
        end
        if (found && best > 0) begin
          r.addr = nbr_addr[pick];
          r.backlog = nbr_backlog[pick];
        end else begin
          r.status = ST_NOROUTE;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp);
    $display("MISMATCH %s: got %0h expected %0h at cycle %0d", what, got, exp,
             cycle_count);
    error_count++;
  endtask

  // Sends one request, predicting its result when it is accepted. Valid stays
  // up after acceptance until the next request, an idle stretch or a drain replaces it.
  task automatic send_request(logic [1:0] mode, logic [15:0] a, logic [14:0] bl,
                              logic ok);
    if (idle_enable && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= mode;
    s_tdata <= {ok, bl, a};
    do @(posedge clk); while (!s_tready);
    pending_results.push_back(table_update(mode, a, bl, ok));
    @(negedge clk);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    // Spare idle time after the last result.
    repeat (20) @(negedge clk);
  endtask

  task automatic write_config(logic [7:0] idx, logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_LOSS_FACTOR) loss_factor = val;
    else if (idx == CFG_LIFETIME) life_max = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Result monitor: sampled at the rising edge.
  always @(posedge clk) begin
    route_result_t exp;
    if (!rst && m_tvalid && m_tready) begin
      result_count++;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", m_tdata, 0);
      end else begin
        exp = pending_results.pop_front();
        if (m_tuser !== exp.status) report_mismatch("status", m_tuser, exp.status);
        if (m_tdata[15:0] !== exp.addr) report_mismatch("address", m_tdata[15:0], exp.addr);
        if (m_tdata[30:16] !== exp.backlog)
          report_mismatch("backlog", m_tdata[30:16], exp.backlog);
        if (m_tdata[31] !== 1'b0) report_mismatch("pad bit", m_tdata[31], 0);
        if (exp.status == ST_DONE && exp.addr != 0) route_hits++;
      end
    end
  end

  // Receiver: random stall bursts, or held off entirely during the pressure test.
  initial begin
    int gap;
    @(negedge clk);
    forever begin
      if (hold_sink) begin
        m_tready <= 1'b0;
        @(negedge clk);
      end else if (idle_enable && $urandom_range(0, 7) == 0) begin
        m_tready <= 1'b0;
        gap = $urandom_range(1, 11);
        repeat (gap) @(negedge clk);
      end else begin
        m_tready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 10_000_000) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Some tests failed");
      $finish;
    end
  end

  // Small address pool so reports, link outcomes and queries hit known neighbors.
  function automatic logic [15:0] pool_addr();
    return ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 19));
  endfunction

  task automatic test_directed();
    send_request(MODE_ROUTE, 16'h0, 15'h7FFF, 1'b0);     // empty table
    send_request(MODE_LINK, 16'hFFFF, 15'h0, 1'b1);      // unknown neighbor
    send_request(MODE_REPORT, 16'hFFFF, 15'h0, 1'b0);
    send_request(MODE_REPORT, 16'h0000, 15'd3, 1'b1);
    send_request(MODE_REPORT, 16'hA5A5, 15'h7FFF, 1'b0); // backlog too large
    send_request(MODE_LINK, 16'hFFFF, 15'h7FFF, 1'b0);
    send_request(MODE_LINK, 16'hFFFF, 15'h0, 1'b0);
    send_request(MODE_LINK, 16'hFFFF, 15'h0, 1'b1);
    send_request(MODE_LINK, 16'h0000, 15'h0, 1'b1);
    send_request(MODE_ROUTE, 16'hFFFF, 15'd24, 1'b1);
    send_request(MODE_ROUTE, 16'h0, 15'd0, 1'b0);        // no route
    send_request(2'd3, 16'h1234, 15'h5555, 1'b1);        // ignored mode
    send_request(MODE_REPORT, 16'h0000, 15'd24, 1'b0);   // refresh known
    send_request(MODE_ROUTE, 16'h0, 15'h7FFF, 1'b0);
    // Fill the table past its capacity.
    for (int i = 0; i < TABLE_ENTRIES; i++)
      send_request(MODE_REPORT, 16'(16'h100 + i), 15'(i), 1'b0);
    wait_drained();
  endtask

  task automatic test_config_extremes();
    write_config(CFG_LOSS_FACTOR, 8'd255);
    write_config(CFG_LIFETIME, 8'd0);
    send_request(MODE_REPORT, 16'hFFFF, 15'd1, 1'b0);
    send_request(MODE_ROUTE, 16'h0, 15'd20000, 1'b0);
    wait_drained();
    write_config(CFG_LOSS_FACTOR, 8'd0);
    write_config(CFG_LIFETIME, 8'd255);
    send_request(MODE_REPORT, 16'hFFFF, 15'd1, 1'b0);
    send_request(MODE_ROUTE, 16'h0, 15'd5, 1'b0);
    wait_drained();
  endtask

  // Random mix against a fresh-looking pool; the table stays full of the
  // directed entries, so only a reset could empty it. Pool addresses refresh them.
  task automatic test_random(int n, bit small_pool);
    logic [1:0] m;
    logic [15:0] a;
    for (int i = 0; i < n; i++) begin
      m = 2'($urandom_range(0, 9) < 4 ? MODE_LINK :
             ($urandom_range(0, 2) == 0 ? MODE_REPORT : MODE_ROUTE));
      if ($urandom_range(0, 30) == 0) m = 2'd3;
      a = small_pool ? 16'(16'h100 + $urandom_range(0, 17)) : pool_addr();
      send_request(m, a, ($urandom_range(0, 3) == 0) ? 15'($urandom) :
                   15'($urandom_range(0, 40)), 1'($urandom));
    end
    wait_drained();
  endtask

  task automatic test_backpressure();
    fork
      begin
        hold_sink = 1'b1;
        repeat (3000) @(negedge clk);
        hold_sink = 1'b0;
      end
      for (int i = 0; i < 8; i++)
        send_request(MODE_LINK, 16'(16'h100 + i), 15'd0, 1'($urandom));
    join
    wait_drained();
  endtask

  initial begin
    loss_factor = 8'd1;
    life_max = 8'd5;
    nbr_count = 0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_config_extremes();
    write_config(CFG_LOSS_FACTOR, 8'd1);
    write_config(CFG_LIFETIME, 8'd5);
    test_random(400, 1'b1);
    write_config(CFG_LOSS_FACTOR, 8'($urandom_range(1, 255)));
    write_config(CFG_LIFETIME, 8'($urandom_range(1, 255)));
    test_random(400, 1'b1);
    test_backpressure();
    write_config(CFG_LOSS_FACTOR, 8'd2);
    // Final stretch with no idling on either side.
    idle_enable = 1'b0;
    test_random(250, 1'b0);
    repeat (1000) @(negedge clk);
    $display("Covered %0d results (%0d routes found) over reports, link updates,",
             result_count, route_hits);
    $display("route queries, a full table, register extremes and a long sink stall.");
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

// File: sim.f
hdl/bpnt_pkg.sv
hdl/bpnt_ctrl.sv
hdl/bpnt_dpath.sv
hdl/backpressure_neighbor_table.sv
tb/sv/testbench.sv
